>>> hdl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg: shared types for the stream group reverser
// Payload structs for both channels, the configuration width and reset value,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sgr_pkg;

    // Width of the group size register and its value after reset.
    localparam int          CFG_W            = 5;
    localparam logic [4:0]  GROUP_SIZE_RESET = 5'd2;

    // One input transaction.
    typedef struct packed {
        logic signed [31:0] item_value;
        logic               list_end;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic signed [31:0] out_value;
        logic               run_last;
        logic               out_list_end;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;     // store the accepted item and update the fill
        logic start;  // latch the read plan of a flush
        logic rd;     // read the next buffered value into the output stage
    } sgr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flush;     // the item on the input would complete a run
        logic run_last;  // the value in the output stage ends the run
    } sgr_status_t;

endpackage

>>> hdl/stream_group_reverser_unit.sv
// ----------------------------------------------------------------------------
// stream_group_reverser_unit: reverses a value stream in groups
// Top level joining the transaction controller and the buffer datapath.
// ----------------------------------------------------------------------------
// Values are buffered until group_size of them are held and are then sent out
// newest first; a list end with a partial group sends the held values oldest
// first, and a group size below 2 passes each value through (after any values
// still held). A flush of n values first accepts and stores the input item,
// then starts the first buffer read, then gives one result per cycle while
// the output does not stall, a rate set by the single read port of the group
// buffer. The input stays stalled from the start of the first read until the
// last result is taken. The group_size register is written with cfg_wr_en and
// takes effect on the next input transaction; values above MAX_GROUP act as
// MAX_GROUP.
// ----------------------------------------------------------------------------
module stream_group_reverser_unit
    import sgr_pkg::*;
#(
    parameter int MAX_GROUP = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item_data,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result_data
);

    sgr_cmd_t    cmd;
    sgr_status_t status;

    // Sequencing of accepts and buffer reads.
    sgr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Group buffer and output stage.
    sgr_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_data),
        .cmd         (cmd),
        .status      (status),
        .result      (result_data)
    );

endmodule

>>> hdl/sgr_datapath.sv
// ----------------------------------------------------------------------------
// sgr_datapath: group buffer, fill tracking and output stage
// Holds the group size register, the group buffer memory, the fill count and
// the read plan that walks the buffer forward or backward during a flush.
// ----------------------------------------------------------------------------
module sgr_datapath
    import sgr_pkg::*;
#(
    parameter int MAX_GROUP = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  item_t              item,
    input  sgr_cmd_t           cmd,
    output sgr_status_t        status,
    output result_t            result
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int KW = (CW > CFG_W) ? CW : CFG_W;

    // Group buffer; entries are only read after they have been written.
    logic signed [31:0] mem [MAX_GROUP];

    logic [CFG_W-1:0]   group_size_reg;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      total_reg;
    logic [CW-1:0]      pos_reg;
    logic               rev_reg;
    logic               lend_reg;
    logic signed [31:0] rd_data_reg;
    logic               run_last_reg;
    logic               list_end_reg;

    logic [CW-1:0]      fill_clamped;
    logic [CW-1:0]      n_c;
    logic [KW-1:0]      k_c;
    logic [KW-1:0]      gs_ext;
    logic               pass_c;
    logic               rev_c;
    logic               flush_c;
    logic [AW-1:0]      wr_addr;
    logic [CW-1:0]      rd_pos;
    logic [AW-1:0]      rd_addr;
    logic               is_last;

    // Decide, for the item on the input, whether it closes a run.
    always_comb
    begin
        fill_clamped = (fill_reg >= CW'(MAX_GROUP)) ? CW'(MAX_GROUP - 1) : fill_reg;
        wr_addr      = fill_clamped[AW-1:0];
        n_c          = fill_clamped + CW'(1);
        gs_ext       = KW'(group_size_reg);
        k_c          = (gs_ext > KW'(MAX_GROUP)) ? KW'(MAX_GROUP) : gs_ext;
        pass_c       = (k_c < KW'(2));
        rev_c        = !pass_c && (KW'(n_c) >= k_c);
        flush_c      = pass_c || rev_c || item.list_end;
        fill_next    = flush_c ? '0 : n_c;
    end

    // Read address: forward for pass-through and a partial group at list end, backward for a full group.
    always_comb
    begin
        rd_pos  = rev_reg ? (total_reg - CW'(1) - pos_reg) : pos_reg;
        rd_addr = rd_pos[AW-1:0];
        is_last = (pos_reg == total_reg - CW'(1));
    end

    // Configuration, fill count and read plan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GROUP_SIZE_RESET;
            fill_reg       <= '0;
            total_reg      <= '0;
            pos_reg        <= '0;
            rev_reg        <= 1'b0;
            lend_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                group_size_reg <= cfg_wr_data;
            end
            if (cmd.wr)
            begin
                fill_reg <= fill_next;
            end
            if (cmd.start)
            begin
                total_reg <= n_c;
                pos_reg   <= '0;
                rev_reg   <= rev_c;
                lend_reg  <= item.list_end;
            end
            else if (cmd.rd)
            begin
                pos_reg <= pos_reg + CW'(1);
            end
        end
    end

    // Buffer write and registered read into the output stage.
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wr_addr] <= item.item_value;
        end
        if (cmd.rd)
        begin
            rd_data_reg  <= mem[rd_addr];
            run_last_reg <= is_last;
            list_end_reg <= is_last && lend_reg;
        end
    end

    assign status.flush    = flush_c;
    assign status.run_last = run_last_reg;

    assign result.out_value    = rd_data_reg;
    assign result.run_last     = run_last_reg;
    assign result.out_list_end = list_end_reg;

endmodule

>>> hdl/sgr_ctrl.sv
// ----------------------------------------------------------------------------
// sgr_ctrl: transaction controller for the stream group reverser
// Accepts input transactions while idle and sequences the buffer reads of a
// flush, one result per cycle while the output side takes them.
// ----------------------------------------------------------------------------
module sgr_ctrl
    import sgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    output logic        result_valid,
    input  logic        result_stall,
    input  sgr_status_t status,
    output sgr_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_SHOW
    } state_t;

    state_t state_reg, state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.wr = 1'b1;
                    if (status.flush)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (!result_stall)
                begin
                    if (status.run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Handshake outputs follow the state alone.
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_SHOW);

endmodule
